// ===== hdl/grid_neighbor_mark_counter_core_macros.svh =====
// Assertion helpers used by the core's RTL file.
`ifndef GRID_NEIGHBOR_MARK_COUNTER_CORE_MACROS_SVH
`define GRID_NEIGHBOR_MARK_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GNMC_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("gnmc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define GNMC_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("gnmc: next-cycle check failed");

`endif

// ===== hdl/gnmc_pkg.sv =====
`timescale 1ns / 1ps

package gnmc_pkg;

  // Default size limits
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;

  // Configuration registers
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_W-1:0] RST_COLUMNS = 11'd8;
  localparam logic [CFG_W-1:0] RST_ROWS    = 11'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } cfg_reg_e;

  // Stream widths
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 16;

  // ASCII result symbols
  localparam logic [6:0] SYM_MARK  = 7'h23;  // '#'
  localparam logic [6:0] SYM_EMPTY = 7'h2E;  // '.'
  localparam logic [6:0] SYM_ZERO  = 7'h30;  // '0'

  // Window geometry: bit 3*k+j is column k (left to right), row j (top down)
  localparam int WIN_COLS = 3;
  localparam logic [8:0] MASK_ALL    = 9'h1EF;  // all but the center
  localparam logic [8:0] MASK_LEFT   = 9'h007;
  localparam logic [8:0] MASK_RIGHT  = 9'h1C0;
  localparam logic [8:0] MASK_TOP    = 9'h049;
  localparam logic [8:0] MASK_BOTTOM = 9'h124;

  // One window column, upper row in bit 0
  typedef struct packed {
    logic lower;
    logic middle;
    logic upper;
  } win_col_t;

  // Frame edges seen by a result cell
  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } edge_t;

endpackage

// ===== hdl/gnmc_ram.sv =====
`timescale 1ns / 1ps

module gnmc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (read-first)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/gnmc_window_cell.sv =====
`timescale 1ns / 1ps

module gnmc_window_cell import gnmc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     shift,
  input  win_col_t col_in,
  output win_col_t col_out
);

  // One window column; takes its right neighbor's column on each shift
  always_ff @(posedge clk) begin
    if (rst) begin
      col_out <= '0;
    end else if (shift) begin
      col_out <= col_in;
    end
  end

endmodule

// ===== hdl/grid_neighbor_mark_counter_core.sv =====
`timescale 1ns / 1ps
`include "grid_neighbor_mark_counter_core_macros.svh"
// Neighbor mark counter over a binary raster streamed in row-major order.
// Slave channel: one transaction per item. s_tuser is the kind (0 = frame
// cell, 1 = flush), s_tdata[0] the marked bit. A frame takes columns*rows
// cells followed by columns+1 flush items; stray items are dropped.
// Master channel: one result per frame cell, in raster order, with m_tuser
// set on the last result of a row and m_tlast on the last of the frame.
// The result for a cell leaves columns+1 items after that cell, passing through
// the line-store read, the window shift and the output register in that order.
// Throughput: one item per clock while the output is not stalled; the rate is set
// by the three-cell window chain shifting once per item, with a forwarding path
// around the line store when back-to-back items use the same column.
// Reset clears the position counters, the window and the output valid and
// loads columns = rows = 8. The line stores need no clearing pass: edge
// masking hides whatever they hold. A config write restarts the frame.
// When a result waits with m_tready low, the output register holds, the
// whole pipeline stalls and s_tready drops in the same cycle.

module grid_neighbor_mark_counter_core import gnmc_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // [0] marked, [7:1] zero
  input  logic                 s_tuser,   // [0] kind
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata,   // [0] is_marked, [4:1] neighbor_count,
                                          // [11:5] symbol, [15:12] zero
  output logic                 m_tuser,   // [0] row_end
  output logic                 m_tlast    // frame_end
);

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int IROW_W = $clog2(MAX_ROWS + 3);

  // configuration
  logic [CFG_W-1:0] cfg_columns;
  logic [CFG_W-1:0] cfg_rows;
  logic [31:0]      cols_wide;
  logic [31:0]      rows_wide;
  logic [CNT_W-1:0] eff_cols;
  logic [ROW_W-1:0] eff_rows;
  logic [IROW_W-1:0] rows_ext;

  // position counters
  logic [COL_W-1:0]  in_column;
  logic [IROW_W-1:0] in_row;
  logic [COL_W-1:0]  out_column;
  logic [ROW_W-1:0]  out_row;

  // acceptance
  logic advance;
  logic take;
  logic item_ok;
  logic go;
  logic cell_in;
  logic frame_open;
  logic emit0;
  logic col_last;
  logic row_end0;
  logic frame_end0;
  edge_t edge0;

  // stage 1: line-store read data
  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  logic             s1_cell;
  logic             s1_emit;
  edge_t            s1_edge;
  logic             s1_row_end;
  logic             s1_frame_end;
  logic             s1_fwd;
  logic [1:0]       s1_fwd_word;
  logic [1:0]       ram_rdata;
  logic [1:0]       s1_word_old;
  logic [1:0]       s1_word_new;
  logic             win_shift;
  win_col_t         new_col;

  // window chain
  win_col_t win [WIN_COLS];
  win_col_t chain_in [WIN_COLS];

  // stage 2: window ready
  logic       s2_valid;
  edge_t      s2_edge;
  logic       s2_row_end;
  logic       s2_frame_end;
  logic [8:0] win_bits;
  logic [8:0] nb_mask;
  logic [8:0] nb_bits;
  logic       center;
  logic [3:0] nb_sum;
  logic [3:0] count;
  logic [6:0] symbol;

  // Effective sizes: zero acts as one, oversize clamps to the limit
  always_comb begin
    cols_wide = 32'(cfg_columns);
    rows_wide = 32'(cfg_rows);
    if (cols_wide == 32'd0) begin
      eff_cols = CNT_W'(1);
    end else if (cols_wide > 32'(MAX_COLUMNS)) begin
      eff_cols = CNT_W'(MAX_COLUMNS);
    end else begin
      eff_cols = CNT_W'(cols_wide);
    end
    if (rows_wide == 32'd0) begin
      eff_rows = ROW_W'(1);
    end else if (rows_wide > 32'(MAX_ROWS)) begin
      eff_rows = ROW_W'(MAX_ROWS);
    end else begin
      eff_rows = ROW_W'(rows_wide);
    end
    rows_ext = IROW_W'(eff_rows);
  end

  // Item acceptance and per-item decisions
  assign advance    = !m_tvalid || m_tready;
  assign s_tready   = advance;
  assign take       = s_tvalid && s_tready;
  assign frame_open = in_row < rows_ext;
  assign item_ok    = s_tuser ? !frame_open : frame_open;
  assign go         = take && item_ok;
  assign cell_in    = !s_tuser && s_tdata[0];
  assign emit0      = (in_row >= IROW_W'(2)) ||
                      ((in_row == IROW_W'(1)) && (in_column != '0));
  assign col_last   = (CNT_W'(in_column) + CNT_W'(1)) >= eff_cols;
  assign row_end0   = (CNT_W'(out_column) + CNT_W'(1)) >= eff_cols;
  assign frame_end0 = row_end0 && ((out_row + ROW_W'(1)) >= eff_rows);
  assign edge0.left   = (out_column == '0);
  assign edge0.right  = row_end0;
  assign edge0.top    = (out_row == '0);
  assign edge0.bottom = (out_row + ROW_W'(1)) >= eff_rows;

  // Config registers and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_columns <= RST_COLUMNS;
      cfg_rows    <= RST_ROWS;
      in_column   <= '0;
      in_row      <= '0;
      out_column  <= '0;
      out_row     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMNS: cfg_columns <= cfg_data;
        REG_ROWS:    cfg_rows    <= cfg_data;
        default:     ;
      endcase
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (go) begin
      if (emit0 && frame_end0) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        if (col_last) begin
          in_column <= '0;
          in_row    <= in_row + IROW_W'(1);
        end else begin
          in_column <= in_column + COL_W'(1);
        end
        if (emit0) begin
          if (row_end0) begin
            out_column <= '0;
            out_row    <= out_row + ROW_W'(1);
          end else begin
            out_column <= out_column + COL_W'(1);
          end
        end
      end
    end
  end

  // Line stores: bit 0 upper row, bit 1 middle row, one word per column
  gnmc_ram #(
    .WIDTH (2),
    .DEPTH (MAX_COLUMNS)
  ) u_line_ram (
    .clk   (clk),
    .we    (advance && s1_valid),
    .waddr (s1_col),
    .wdata (s1_word_new),
    .re    (go),
    .raddr (in_column),
    .rdata (ram_rdata)
  );

  // Forward the word being written when the next item reads the same column
  assign s1_word_old = s1_fwd ? s1_fwd_word : ram_rdata;
  assign s1_word_new = {s1_cell, s1_word_old[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && go) begin
      s1_col       <= in_column;
      s1_cell      <= cell_in;
      s1_emit      <= emit0;
      s1_edge      <= edge0;
      s1_row_end   <= row_end0;
      s1_frame_end <= frame_end0;
      s1_fwd       <= s1_valid && (s1_col == in_column);
      s1_fwd_word  <= s1_word_new;
    end
  end

  // Window chain: new column enters at the right, moves one cell left per item
  assign win_shift      = advance && s1_valid;
  assign new_col.upper  = s1_word_old[0];
  assign new_col.middle = s1_word_old[1];
  assign new_col.lower  = s1_cell;

  for (genvar k = 0; k < WIN_COLS; k++) begin : g_win
    if (k == WIN_COLS - 1) begin : g_head
      assign chain_in[k] = new_col;
    end else begin : g_link
      assign chain_in[k] = win[k+1];
    end
    gnmc_window_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (win_shift),
      .col_in  (chain_in[k]),
      .col_out (win[k])
    );
  end

  // Stage 2 control travels alongside the window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      s2_edge      <= s1_edge;
      s2_row_end   <= s1_row_end;
      s2_frame_end <= s1_frame_end;
    end
  end

  // Neighbor count with frame edges masked off
  always_comb begin
    win_bits = {win[2], win[1], win[0]};
    center   = win_bits[4];
    nb_mask  = MASK_ALL;
    if (s2_edge.left)   nb_mask = nb_mask & ~MASK_LEFT;
    if (s2_edge.right)  nb_mask = nb_mask & ~MASK_RIGHT;
    if (s2_edge.top)    nb_mask = nb_mask & ~MASK_TOP;
    if (s2_edge.bottom) nb_mask = nb_mask & ~MASK_BOTTOM;
    nb_bits = win_bits & nb_mask;
    nb_sum  = '0;
    for (int i = 0; i < 9; i++) begin
      nb_sum = nb_sum + 4'(nb_bits[i]);
    end
    count = center ? 4'd0 : nb_sum;
    priority if (center) begin
      symbol = SYM_MARK;
    end else if (count == 4'd0) begin
      symbol = SYM_EMPTY;
    end else begin
      symbol = SYM_ZERO + 7'(count);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      m_tdata <= {4'd0, symbol, count, center};
      m_tuser <= s2_row_end;
      m_tlast <= s2_frame_end;
    end
  end

  // Checks
  `GNMC_ASSERT_IMP(a_frame_end_on_row_end, clk, rst, m_tvalid && m_tlast, m_tuser)
  `GNMC_ASSERT_IMP(a_marked_result, clk, rst, m_tvalid && m_tdata[0],
                   (m_tdata[4:1] == 4'd0) && (m_tdata[11:5] == SYM_MARK))
  `GNMC_ASSERT_NXT(a_window_to_output, clk, rst, advance && s2_valid, m_tvalid)
  `GNMC_ASSERT_IMP(a_in_row_bound, clk, rst, 1'b1, in_row <= rows_ext + IROW_W'(2))

endmodule
